[hw/rtl/ycr2rgb_pkg.sv]
// Shared types, register codes, term ROMs and arithmetic helpers for the YCbCr to RGB converter.
package ycr2rgb_pkg;

    localparam int SAMPLE_W     = 10;
    localparam int LEVEL_W      = 8;
    localparam int TERM_W       = 14;
    localparam int SUM_W        = 15;
    localparam int PIXEL_W      = 24;
    localparam int MASK_W       = 16;
    localparam int GROUP_PIXELS = 4;
    localparam int ROM_DEPTH    = 256;
    localparam int TERM_SCALE   = 1000000;

    localparam logic MODE_GROUP = 1'b0;
    localparam logic MODE_CELL  = 1'b1;

    localparam logic [1:0] REG_INDEX_OFFSET = 2'd0;
    localparam logic [1:0] REG_LEVEL_MIN    = 2'd1;
    localparam logic [1:0] REG_LUMA_MAX     = 2'd2;
    localparam logic [1:0] REG_CHROMA_MAX   = 2'd3;

    localparam logic [1:0] ROW_LAST = 2'd3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [LEVEL_W-1:0]         level_t;
    typedef logic signed [TERM_W-1:0]   term_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic [PIXEL_W-1:0]         pixel_t;
    typedef term_t                      term_rom_t [ROM_DEPTH];

    typedef struct packed {
        level_t index_offset;
        level_t level_min;
        level_t luma_max;
        level_t chroma_max;
    } cfg_t;

    typedef struct packed {
        term_t bc;
        term_t gc;
        term_t rc;
    } chroma_terms_t;

    // trunc((a*L + b) / 1e6) for every level, evaluated at elaboration
    function automatic term_rom_t build_rom(longint a, longint b);
        term_rom_t rom;
        longint    v;
        for (int i = 0; i < ROM_DEPTH; i++) begin
            v = (a * longint'(i) + b) / TERM_SCALE;
            rom[i] = TERM_W'(v);
        end
        return rom;
    endfunction

    localparam term_rom_t YTERM_ROM = build_rom(64'sd18630144, 64'sd8000000);
    localparam term_rom_t RCR_ROM   = build_rom(64'sd25542912, -64'sd3567575040);
    localparam term_rom_t GCR_ROM   = build_rom(-64'sd13007168, 64'sd0);
    localparam term_rom_t GCB_ROM   = build_rom(-64'sd6287568, 64'sd2171644638);
    localparam term_rom_t BCB_ROM   = build_rom(64'sd32262496, -64'sd4427681008);

    // offset add, raise to lo, then lower to hi (hi wins when crossed)
    function automatic level_t clamp_level(sample_t s, level_t offset, level_t lo, level_t hi);
        logic signed [SAMPLE_W:0] v;
        logic signed [SAMPLE_W:0] lo_s;
        logic signed [SAMPLE_W:0] hi_s;
        v    = (SAMPLE_W+1)'(s) + $signed({{(SAMPLE_W+1-LEVEL_W){1'b0}}, offset});
        lo_s = $signed({{(SAMPLE_W+1-LEVEL_W){1'b0}}, lo});
        hi_s = $signed({{(SAMPLE_W+1-LEVEL_W){1'b0}}, hi});
        if (v < lo_s) begin
            v = lo_s;
        end
        if (v > hi_s) begin
            v = hi_s;
        end
        return v[LEVEL_W-1:0];
    endfunction

    function automatic level_t chan(sum_t s);
        logic signed [SUM_W-5:0] v;
        v = (SUM_W-4)'(s >>> 4);
        if (s < 0) begin
            return '0;
        end else if (v > 255) begin
            return 8'hFF;
        end else begin
            return v[LEVEL_W-1:0];
        end
    endfunction

endpackage

[hw/rtl/ycr2rgb_chroma.sv]
// Chroma path: clamps Cb/Cr and looks up the shared red, green and blue chroma terms.
module ycr2rgb_chroma
    import ycr2rgb_pkg::*;
(
    input  logic          aclk,
    input  logic          en,
    input  cfg_t          cfg,
    input  sample_t       cb_in,
    input  sample_t       cr_in,
    output chroma_terms_t terms
);

    level_t        lcb_reg;
    level_t        lcr_reg;
    chroma_terms_t terms_reg;
    chroma_terms_t terms_next;

    always_comb begin
        terms_next.bc = BCB_ROM[lcb_reg];
        terms_next.gc = GCR_ROM[lcr_reg] + GCB_ROM[lcb_reg];
        terms_next.rc = RCR_ROM[lcr_reg];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lcb_reg   <= clamp_level(cb_in, cfg.index_offset, cfg.level_min, cfg.chroma_max);
            lcr_reg   <= clamp_level(cr_in, cfg.index_offset, cfg.level_min, cfg.chroma_max);
            terms_reg <= terms_next;
        end
    end

    assign terms = terms_reg;

endmodule

[hw/rtl/ycr2rgb_lane.sv]
// Luma lane: clamps one luma sample, looks up its term and forms one BGR pixel.
module ycr2rgb_lane
    import ycr2rgb_pkg::*;
(
    input  logic          aclk,
    input  logic          en,
    input  cfg_t          cfg,
    input  sample_t       luma,
    input  chroma_terms_t terms,
    output pixel_t        pixel
);

    level_t level_reg;
    term_t  yterm_reg;
    pixel_t pixel_reg;
    pixel_t pixel_next;
    sum_t   b_sum;
    sum_t   g_sum;
    sum_t   r_sum;

    always_comb begin
        b_sum      = SUM_W'(yterm_reg) + SUM_W'(terms.bc);
        g_sum      = SUM_W'(yterm_reg) + SUM_W'(terms.gc);
        r_sum      = SUM_W'(yterm_reg) + SUM_W'(terms.rc);
        pixel_next = {chan(r_sum), chan(g_sum), chan(b_sum)};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            level_reg <= clamp_level(luma, cfg.index_offset, cfg.level_min, cfg.luma_max);
            yterm_reg <= YTERM_ROM[level_reg];
            pixel_reg <= pixel_next;
        end
    end

    assign pixel = pixel_reg;

endmodule

[hw/rtl/ycr2rgb_merge.sv]
// Merge stage: builds group results or the four cell rows and holds the output request.
module ycr2rgb_merge
    import ycr2rgb_pkg::*;
#(
    parameter int PIXELS_PER_ITEM = 4
)
(
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  in_mode,
    input  logic [MASK_W-1:0]                     in_mask,
    input  logic [GROUP_PIXELS-1:0][PIXEL_W-1:0]  in_pixels,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [GROUP_PIXELS-1:0][PIXEL_W-1:0]  out_pixels,
    output logic                                  out_last
);

    logic                                 valid_reg;
    logic                                 valid_next;
    logic                                 last_reg;
    logic                                 last_next;
    logic [1:0]                           row_reg;
    logic [1:0]                           row_next;
    logic [MASK_W-1:0]                    mask_reg;
    logic [MASK_W-1:0]                    mask_next;
    pixel_t                               col0_reg;
    pixel_t                               col0_next;
    pixel_t                               col1_reg;
    pixel_t                               col1_next;
    logic [GROUP_PIXELS-1:0][PIXEL_W-1:0] pix_reg;
    logic [GROUP_PIXELS-1:0][PIXEL_W-1:0] pix_next;
    logic                                 take;

    // row r, column p uses mask bit 15 - (4r + p)
    function automatic pixel_t cell_pixel(logic [MASK_W-1:0] mask, logic [1:0] row,
                                          logic [1:0] col, pixel_t c0, pixel_t c1);
        logic [3:0] bit_idx;
        bit_idx = {~row, ~col};
        return mask[bit_idx] ? c1 : c0;
    endfunction

    assign in_ready = !valid_reg || (out_ready && last_reg);
    assign take     = in_valid && in_ready;

    always_comb begin
        valid_next = valid_reg;
        last_next  = last_reg;
        row_next   = row_reg;
        mask_next  = mask_reg;
        col0_next  = col0_reg;
        col1_next  = col1_reg;
        pix_next   = pix_reg;
        if (take) begin
            valid_next = 1'b1;
            mask_next  = in_mask;
            col0_next  = in_pixels[0];
            col1_next  = in_pixels[1];
            row_next   = '0;
            last_next  = (in_mode == MODE_GROUP);
            for (int p = 0; p < GROUP_PIXELS; p++) begin
                if (p >= PIXELS_PER_ITEM) begin
                    pix_next[p] = '0;
                end else if (in_mode == MODE_GROUP) begin
                    pix_next[p] = in_pixels[p];
                end else begin
                    pix_next[p] = cell_pixel(in_mask, 2'd0, 2'(p), in_pixels[0], in_pixels[1]);
                end
            end
        end else if (valid_reg && out_ready) begin
            if (last_reg) begin
                valid_next = 1'b0;
            end else begin
                row_next  = row_reg + 2'd1;
                last_next = (row_next == ROW_LAST);
                for (int p = 0; p < GROUP_PIXELS; p++) begin
                    if (p >= PIXELS_PER_ITEM) begin
                        pix_next[p] = '0;
                    end else begin
                        pix_next[p] = cell_pixel(mask_reg, row_next, 2'(p), col0_reg, col1_reg);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
            row_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            last_reg  <= last_next;
            row_reg   <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        mask_reg <= mask_next;
        col0_reg <= col0_next;
        col1_reg <= col1_next;
        pix_reg  <= pix_next;
    end

    assign out_valid  = valid_reg;
    assign out_pixels = pix_reg;
    assign out_last   = last_reg;

endmodule

[hw/rtl/ycbcr_to_rgb_group_converter.sv]
// Top level of the YCbCr to RGB group converter: config registers, lanes and pipeline control.
//
// Input stream (s_*): one request carries four luma samples, a shared Cb/Cr pair and a
// 16-bit cell mask in s_tdata; s_tuser selects group mode (0) or two-colour cell mode (1).
// Output stream (m_*): m_tdata holds four BGR pixels, m_tlast marks the final result of
// a request. Group mode gives one result, cell mode four row results.
// Up to four luma lanes and one chroma path run in parallel. Each lane is a three-stage
// pipeline (level clamp, term ROM lookup, channel add and saturate) followed by the
// output register; the chroma path registers its level clamp and term ROM lookup.
// Throughput: one group-mode request per cycle while m_tready is high; a cell-mode
// request holds the output register until its four rows are taken; the pipeline waits for it.
// When m_tready is low the pipeline freezes as soon as its last stage holds a request
// the output register cannot take, and s_tready drops with it; nothing is lost or repeated.
// Configuration goes through the APB port at byte addresses 0, 4, 8, 12
// (index_offset, level_min, luma_max, chroma_max); write it only while idle.
// Reset (aresetn low, synchronous) empties the pipeline and loads the register
// defaults 0, 16, 235 and 240.
module ycbcr_to_rgb_group_converter
    import ycr2rgb_pkg::*;
#(
    parameter int PIXELS_PER_ITEM = 4
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // luma0, luma1, luma2, luma3, cb_in, cr_in, cell_mask, 4 zero bits
    input  logic [79:0] s_tdata,
    // mode
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel0, pixel1, pixel2, pixel3
    output logic [95:0] m_tdata,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LANE_COUNT = (PIXELS_PER_ITEM < 2) ? 2 :
                                (PIXELS_PER_ITEM > GROUP_PIXELS) ? GROUP_PIXELS :
                                PIXELS_PER_ITEM;
    localparam int CB_LSB   = GROUP_PIXELS * SAMPLE_W;
    localparam int CR_LSB   = CB_LSB + SAMPLE_W;
    localparam int MASK_LSB = CR_LSB + SAMPLE_W;

    cfg_t                                 cfg_reg;
    logic                                 en;
    logic [2:0]                           valid_reg;
    logic [2:0]                           mode_reg;
    logic [2:0][MASK_W-1:0]               mask_reg;
    chroma_terms_t                        terms;
    logic [GROUP_PIXELS-1:0][PIXEL_W-1:0] lane_pixels;
    logic                                 merge_ready;
    logic                                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.index_offset <= 8'd0;
            cfg_reg.level_min    <= 8'd16;
            cfg_reg.luma_max     <= 8'd235;
            cfg_reg.chroma_max   <= 8'd240;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_INDEX_OFFSET: cfg_reg.index_offset <= pwdata[LEVEL_W-1:0];
                REG_LEVEL_MIN:    cfg_reg.level_min    <= pwdata[LEVEL_W-1:0];
                REG_LUMA_MAX:     cfg_reg.luma_max     <= pwdata[LEVEL_W-1:0];
                REG_CHROMA_MAX:   cfg_reg.chroma_max   <= pwdata[LEVEL_W-1:0];
                default:          cfg_reg.index_offset <= cfg_reg.index_offset;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_INDEX_OFFSET: prdata = {24'd0, cfg_reg.index_offset};
            REG_LEVEL_MIN:    prdata = {24'd0, cfg_reg.level_min};
            REG_LUMA_MAX:     prdata = {24'd0, cfg_reg.luma_max};
            REG_CHROMA_MAX:   prdata = {24'd0, cfg_reg.chroma_max};
            default:          prdata = '0;
        endcase
    end

    // pipeline moves as one block whenever the last stage can hand over
    assign en       = !valid_reg[2] || merge_ready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[1:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode_reg <= {mode_reg[1:0], s_tuser[0]};
            mask_reg <= {mask_reg[1:0], s_tdata[MASK_LSB +: MASK_W]};
        end
    end

    ycr2rgb_chroma u_chroma (
        .aclk  (aclk),
        .en    (en),
        .cfg   (cfg_reg),
        .cb_in (s_tdata[CB_LSB +: SAMPLE_W]),
        .cr_in (s_tdata[CR_LSB +: SAMPLE_W]),
        .terms (terms)
    );

    for (genvar k = 0; k < GROUP_PIXELS; k++) begin : g_lane
        if (k < LANE_COUNT) begin : g_on
            ycr2rgb_lane u_lane (
                .aclk  (aclk),
                .en    (en),
                .cfg   (cfg_reg),
                .luma  (s_tdata[k*SAMPLE_W +: SAMPLE_W]),
                .terms (terms),
                .pixel (lane_pixels[k])
            );
        end else begin : g_off
            assign lane_pixels[k] = '0;
        end
    end

    ycr2rgb_merge #(
        .PIXELS_PER_ITEM (PIXELS_PER_ITEM)
    ) u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (valid_reg[2]),
        .in_ready   (merge_ready),
        .in_mode    (mode_reg[2]),
        .in_mask    (mask_reg[2]),
        .in_pixels  (lane_pixels),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_pixels (m_tdata),
        .out_last   (m_tlast)
    );

endmodule
